@@ rtl/shape_hit_test_top_macros.svh @@
// Assertion macros used by the shape hit test checker.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef SHAPE_HIT_TEST_TOP_MACROS_SVH
`define SHAPE_HIT_TEST_TOP_MACROS_SVH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define SHT_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define SHT_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/sht_pkg.sv @@
// Shared types and constants for the shape hit test block.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sht_pkg;

  // Width of every coordinate field on the input channel
  localparam int unsigned FIELD_WIDTH = 16;
  // Coordinates are read from the low COORD_WIDTH bits of each field
  localparam int unsigned COORD_WIDTH = 16;

  localparam int unsigned RADIUS_WIDTH = 10;
  localparam logic [RADIUS_WIDTH-1:0] CATCH_RADIUS_RST = 10'd80;

  localparam int unsigned FUNC_WIDTH = 2;
  typedef logic [FUNC_WIDTH-1:0] func_t;

  localparam func_t FUNC_LINE    = 2'd0;
  localparam func_t FUNC_ELLIPSE = 2'd1;
  localparam func_t FUNC_RECT    = 2'd2;

  typedef logic signed [FIELD_WIDTH-1:0] field_t;
  typedef logic [RADIUS_WIDTH-1:0]       radius_t;

endpackage

`default_nettype wire

@@ rtl/sht_if.sv @@
// Valid/ready channel interfaces of the shape hit test block: query words,
// result words and catch radius writes. Depends on sht_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sht_in_if;
  logic            valid;
  logic            ready;
  sht_pkg::func_t  func;
  sht_pkg::field_t corner0_x;
  sht_pkg::field_t corner0_y;
  sht_pkg::field_t corner1_x;
  sht_pkg::field_t corner1_y;
  sht_pkg::field_t corner2_x;
  sht_pkg::field_t corner2_y;
  sht_pkg::field_t query_x;
  sht_pkg::field_t query_y;

  modport source (
    output valid, func, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, query_x, query_y,
    input  ready
  );
  modport sink (
    input  valid, func, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, query_x, query_y,
    output ready
  );
endinterface

interface sht_res_if;
  logic valid;
  logic ready;
  logic hit;
  logic degenerate;

  modport source (output valid, hit, degenerate, input ready);
  modport sink (input valid, hit, degenerate, output ready);
endinterface

interface sht_cfg_if;
  logic             valid;
  logic             ready;
  sht_pkg::radius_t data;

  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

@@ rtl/shape_hit_test_top.sv @@
// Shape hit test: five-stage pipeline testing a query point against a line,
// ellipse or rectangle. Depends on sht_pkg and the channels in sht_if.sv.
`timescale 1ns / 1ps
`default_nettype none

// Takes one query word per clock unless every stage is full and the result is
// stalled, and returns one result word per query, in order.
// The five register stages are: coordinate differences and the rectangle
// test, the first products, the sums, the wide squares, and the final
// compare into the output register. The squaring stage (up to 32 x 32 bit
// products) sets the stage depth. Every stage has its own valid bit and
// fills bubbles while the output is stalled, so a query is still accepted
// while a finished result waits. The catch radius write port is always
// ready; write it only while no query is in flight.
module shape_hit_test_top (
  input  logic      clk_i,
  input  logic      rst_ni,
  sht_in_if.sink    in_i,
  sht_cfg_if.sink   cfg_i,
  sht_res_if.source res_o
);

  import sht_pkg::*;

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned DW   = CW + 1;          // coordinate difference
  localparam int unsigned EW   = CW + 3;          // doubled ellipse offset
  localparam int unsigned PW   = 2 * DW;          // signed product
  localparam int unsigned SW   = PW + 1;          // sum of two products
  localparam int unsigned SQW  = 2 * CW;          // square of a difference
  localparam int unsigned LW   = SQW + 1;         // squared length
  localparam int unsigned R2W  = 2 * RADIUS_WIDTH;
  localparam int unsigned RLW  = R2W + LW;        // r^2 * len^2
  localparam int unsigned CK   = (RLW + 1) / 2;   // kept cross product bits
  localparam int unsigned CQW  = 2 * CK;
  localparam int unsigned MW   = 2 * CW;          // ellipse scaled offsets
  localparam int unsigned MQW  = 2 * MW;

  localparam logic [R2W-1:0] R2_RST = R2W'(CATCH_RADIUS_RST) * R2W'(CATCH_RADIUS_RST);

  typedef struct packed {
    func_t                func;
    logic                 rect_hit;
    logic signed [DW-1:0] ux;
    logic signed [DW-1:0] uy;
    logic signed [DW-1:0] px;
    logic signed [DW-1:0] py;
    logic signed [DW-1:0] vx;
    logic signed [DW-1:0] vy;
    logic [CW-1:0]        ew;
    logic [CW-1:0]        eh;
    logic [CW+1:0]        edx;
    logic [CW+1:0]        edy;
  } s1_t;

  typedef struct packed {
    func_t                func;
    logic                 rect_hit;
    logic                 line_zero;
    logic [SQW-1:0]       ux2;
    logic [SQW-1:0]       uy2;
    logic [SQW-1:0]       px2;
    logic [SQW-1:0]       py2;
    logic [SQW-1:0]       vx2;
    logic [SQW-1:0]       vy2;
    logic signed [PW-1:0] dot1;
    logic signed [PW-1:0] dot2;
    logic signed [PW-1:0] cr1;
    logic signed [PW-1:0] cr2;
    logic                 ell_zero;
    logic                 ell_out;
    logic [MW-1:0]        ea;
    logic [MW-1:0]        eb;
    logic [MW-1:0]        ep;
  } s2_t;

  typedef struct packed {
    func_t                func;
    logic                 rect_hit;
    logic                 line_zero;
    logic [LW-1:0]        len2;
    logic signed [SW-1:0] dot;
    logic [LW-1:0]        d0;
    logic [LW-1:0]        d1;
    logic [CK-1:0]        cr;
    logic                 cbig;
    logic                 ell_zero;
    logic                 ell_out;
    logic [MW-1:0]        ea;
    logic [MW-1:0]        eb;
    logic [MW-1:0]        ep;
  } s3_t;

  typedef struct packed {
    func_t          func;
    logic           rect_hit;
    logic           line_zero;
    logic           near0;
    logic           near1;
    logic           hit0;
    logic           hit1;
    logic           cbig;
    logic [CQW-1:0] c2;
    logic [RLW-1:0] rl;
    logic           ell_zero;
    logic           ell_out;
    logic [MQW-1:0] ea2;
    logic [MQW-1:0] eb2;
    logic [MQW-1:0] ep2;
  } s4_t;

  function automatic logic signed [DW-1:0] diff(input logic signed [CW-1:0] a,
                                                 input logic signed [CW-1:0] b);
    diff = {a[CW-1], a} - {b[CW-1], b};
  endfunction

  function automatic logic signed [PW-1:0] smul(input logic signed [DW-1:0] a,
                                                 input logic signed [DW-1:0] b);
    smul = a * b;
  endfunction

  function automatic logic [SQW-1:0] sqr(input logic signed [DW-1:0] a);
    logic signed [PW-1:0] p;
    p   = a * a;
    sqr = p[SQW-1:0];
  endfunction

  // Stage handshake
  logic v1_q, v2_q, v3_q, v4_q, vo_q;
  logic en1, en2, en3, en4, eno;

  assign eno = !vo_q || res_o.ready;
  assign en4 = !v4_q || eno;
  assign en3 = !v3_q || en4;
  assign en2 = !v2_q || en3;
  assign en1 = !v1_q || en2;

  assign in_i.ready  = en1;
  assign cfg_i.ready = 1'b1;

  // Catch radius, kept squared
  logic [R2W-1:0] r2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r2_q <= R2_RST;
    end else if (cfg_i.valid) begin
      r2_q <= R2W'(cfg_i.data) * R2W'(cfg_i.data);
    end
  end

  // Stage 1: differences, ellipse offsets, rectangle test
  logic signed [CW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, qx, qy;
  logic signed [EW-1:0] dx2, dy2;
  logic signed [DW-1:0] hy;
  s1_t                  s1_d, s1_q;

  assign c0x = in_i.corner0_x[CW-1:0];
  assign c0y = in_i.corner0_y[CW-1:0];
  assign c1x = in_i.corner1_x[CW-1:0];
  assign c1y = in_i.corner1_y[CW-1:0];
  assign c2x = in_i.corner2_x[CW-1:0];
  assign c2y = in_i.corner2_y[CW-1:0];
  assign qx  = in_i.query_x[CW-1:0];
  assign qy  = in_i.query_y[CW-1:0];

  always_comb begin
    s1_d      = '0;
    s1_d.func = in_i.func;
    s1_d.ux   = diff(c1x, c0x);
    s1_d.uy   = diff(c1y, c0y);
    s1_d.px   = diff(qx, c0x);
    s1_d.py   = diff(qy, c0y);
    s1_d.vx   = diff(qx, c1x);
    s1_d.vy   = diff(qy, c1y);

    hy = diff(c2y, c1y);
    s1_d.ew = s1_d.ux[DW-1] ? CW'(-s1_d.ux) : s1_d.ux[CW-1:0];
    s1_d.eh = hy[DW-1] ? CW'(-hy) : hy[CW-1:0];

    // offsets from the center, doubled to stay integer
    dx2 = {{2{qx[CW-1]}}, qx, 1'b0} - {{3{c0x[CW-1]}}, c0x} - {{3{c2x[CW-1]}}, c2x};
    dy2 = {{2{qy[CW-1]}}, qy, 1'b0} - {{3{c0y[CW-1]}}, c0y} - {{3{c2y[CW-1]}}, c2y};
    s1_d.edx = dx2[EW-1] ? (CW+2)'(-dx2) : dx2[CW+1:0];
    s1_d.edy = dy2[EW-1] ? (CW+2)'(-dy2) : dy2[CW+1:0];

    s1_d.rect_hit = ((qx >= c0x && qx <= c2x) || (qx >= c2x && qx <= c0x)) &&
                    ((qy >= c0y && qy <= c2y) || (qy >= c2y && qy <= c0y));
  end

  // Stage 2: products
  s2_t s2_d, s2_q;

  always_comb begin
    s2_d           = '0;
    s2_d.func      = s1_q.func;
    s2_d.rect_hit  = s1_q.rect_hit;
    s2_d.line_zero = (s1_q.ux == '0) && (s1_q.uy == '0);
    s2_d.ux2       = sqr(s1_q.ux);
    s2_d.uy2       = sqr(s1_q.uy);
    s2_d.px2       = sqr(s1_q.px);
    s2_d.py2       = sqr(s1_q.py);
    s2_d.vx2       = sqr(s1_q.vx);
    s2_d.vy2       = sqr(s1_q.vy);
    s2_d.dot1      = smul(s1_q.px, s1_q.ux);
    s2_d.dot2      = smul(s1_q.py, s1_q.uy);
    s2_d.cr1       = smul(s1_q.px, s1_q.uy);
    s2_d.cr2       = smul(s1_q.py, s1_q.ux);
    s2_d.ell_zero  = (s1_q.ew == '0) || (s1_q.eh == '0);
    // outside the bounding box: the scaled offsets below are then unused
    s2_d.ell_out   = (s1_q.edx > {2'b00, s1_q.ew}) || (s1_q.edy > {2'b00, s1_q.eh});
    s2_d.ea        = MW'(s1_q.edx[CW-1:0]) * MW'(s1_q.eh);
    s2_d.eb        = MW'(s1_q.edy[CW-1:0]) * MW'(s1_q.ew);
    s2_d.ep        = MW'(s1_q.ew) * MW'(s1_q.eh);
  end

  // Stage 3: sums
  logic signed [SW-1:0] xprod;
  logic [SW-1:0]        cabs;
  s3_t                  s3_d, s3_q;

  always_comb begin
    s3_d           = '0;
    s3_d.func      = s2_q.func;
    s3_d.rect_hit  = s2_q.rect_hit;
    s3_d.line_zero = s2_q.line_zero;
    s3_d.len2      = {1'b0, s2_q.ux2} + {1'b0, s2_q.uy2};
    s3_d.d0        = {1'b0, s2_q.px2} + {1'b0, s2_q.py2};
    s3_d.d1        = {1'b0, s2_q.vx2} + {1'b0, s2_q.vy2};
    s3_d.dot       = {s2_q.dot1[PW-1], s2_q.dot1} + {s2_q.dot2[PW-1], s2_q.dot2};
    xprod          = {s2_q.cr1[PW-1], s2_q.cr1} - {s2_q.cr2[PW-1], s2_q.cr2};
    cabs           = xprod[SW-1] ? -xprod : xprod;
    s3_d.cr        = cabs[CK-1:0];
    // a cross product this large can never be within the radius
    s3_d.cbig      = |cabs[SW-1:CK];
    s3_d.ell_zero  = s2_q.ell_zero;
    s3_d.ell_out   = s2_q.ell_out;
    s3_d.ea        = s2_q.ea;
    s3_d.eb        = s2_q.eb;
    s3_d.ep        = s2_q.ep;
  end

  // Stage 4: region select and wide squares
  s4_t s4_d, s4_q;

  always_comb begin
    s4_d           = '0;
    s4_d.func      = s3_q.func;
    s4_d.rect_hit  = s3_q.rect_hit;
    s4_d.line_zero = s3_q.line_zero;
    s4_d.near0     = s3_q.dot[SW-1] || (s3_q.dot == '0);
    s4_d.near1     = !s3_q.dot[SW-1] && (s3_q.dot[SW-2:0] >= (SW-1)'(s3_q.len2));
    s4_d.hit0      = s3_q.d0 <= LW'(r2_q);
    s4_d.hit1      = s3_q.d1 <= LW'(r2_q);
    s4_d.cbig      = s3_q.cbig;
    s4_d.c2        = CQW'(s3_q.cr) * CQW'(s3_q.cr);
    s4_d.rl        = RLW'(r2_q) * RLW'(s3_q.len2);
    s4_d.ell_zero  = s3_q.ell_zero;
    s4_d.ell_out   = s3_q.ell_out;
    s4_d.ea2       = MQW'(s3_q.ea) * MQW'(s3_q.ea);
    s4_d.eb2       = MQW'(s3_q.eb) * MQW'(s3_q.eb);
    s4_d.ep2       = MQW'(s3_q.ep) * MQW'(s3_q.ep);
  end

  // Stage 5: final compare into the output register
  logic line_hit, ell_hit;
  logic hit_d, deg_d, hit_q, deg_q;

  always_comb begin
    if (s4_q.near0) begin
      line_hit = s4_q.hit0;
    end else if (s4_q.near1) begin
      line_hit = s4_q.hit1;
    end else begin
      line_hit = !s4_q.cbig && (s4_q.c2 <= CQW'(s4_q.rl));
    end
    ell_hit = !s4_q.ell_out &&
              (({1'b0, s4_q.ea2} + {1'b0, s4_q.eb2}) <= {1'b0, s4_q.ep2});

    unique case (s4_q.func)
      FUNC_LINE: begin
        hit_d = !s4_q.line_zero && line_hit;
        deg_d = s4_q.line_zero;
      end
      FUNC_ELLIPSE: begin
        hit_d = !s4_q.ell_zero && ell_hit;
        deg_d = s4_q.ell_zero;
      end
      FUNC_RECT: begin
        hit_d = s4_q.rect_hit;
        deg_d = 1'b0;
      end
      default: begin
        hit_d = 1'b0;
        deg_d = 1'b0;
      end
    endcase
  end

  // Valid bits travel with the words
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_i.valid;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
      if (en4) v4_q <= v3_q;
      if (eno) vo_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) s1_q <= s1_d;
    if (en2) s2_q <= s2_d;
    if (en3) s3_q <= s3_d;
    if (en4) s4_q <= s4_d;
    if (eno) begin
      hit_q <= hit_d;
      deg_q <= deg_d;
    end
  end

  assign res_o.valid      = vo_q;
  assign res_o.hit        = hit_q;
  assign res_o.degenerate = deg_q;

endmodule

`default_nettype wire

@@ rtl/sht_checker.sv @@
// Port-level checks for shape_hit_test_top, attached by the bind below.
// Depends on shape_hit_test_top_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "shape_hit_test_top_macros.svh"

module sht_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic res_valid_i,
  input logic res_ready_i,
  input logic res_hit_i,
  input logic res_degenerate_i
);

  `SHT_ASSERT_NEXT(a_res_hold, res_valid_i && !res_ready_i, res_valid_i, "result word dropped while stalled")

  `SHT_ASSERT_NEXT(a_res_stable, res_valid_i && !res_ready_i, $stable(res_hit_i) && $stable(res_degenerate_i), "result word changed while stalled")

  // a degenerate shape is never hit
  `SHT_ASSERT_NOW(a_hit_not_deg, res_valid_i, !(res_hit_i && res_degenerate_i), "hit reported on degenerate shape")

  // back-pressure at the input only comes from a stalled, full output
  `SHT_ASSERT_NOW(a_stall_source, !in_ready_i, res_valid_i && !res_ready_i, "input stalled without output stall")

endmodule

bind shape_hit_test_top sht_checker u_sht_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_ready_i       (in_i.ready),
  .res_valid_i      (res_o.valid),
  .res_ready_i      (res_o.ready),
  .res_hit_i        (res_o.hit),
  .res_degenerate_i (res_o.degenerate)
);

`default_nettype wire
